/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the BCD time field editor.
// No dependencies; define NO_ASSERTIONS to compile the macros away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every rising edge, ignored while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that a condition never holds at a rising edge.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* hw/rtl/bte_pkg.sv */
// Package for the BCD time field editor: action codes, register masks
// and BCD helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bte_pkg;

   typedef enum logic [2:0] {
      ACT_TOGGLE  = 3'd0,
      ACT_HOUR    = 3'd1,
      ACT_MINUTE  = 3'd2,
      ACT_DAY     = 3'd3,
      ACT_MONTH   = 3'd4,
      ACT_YEAR    = 3'd5,
      ACT_WEEKDAY = 3'd6,
      ACT_NONE    = 3'd7
   } action_type;

   localparam int unsigned BIT_12H_POS = 7;
   localparam int unsigned BIT_PM_POS  = 5;

   localparam logic [7:0] MASK_H24  = 8'h3F;
   localparam logic [7:0] MASK_H12  = 8'h1F;
   localparam logic [7:0] MASK_MIN  = 8'h7F;
   localparam logic [7:0] MASK_DAY  = 8'h3F;
   localparam logic [7:0] MASK_MON  = 8'h1F;
   localparam logic [7:0] MASK_YEAR = 8'hFF;

   localparam logic [7:0] TOP_H24  = 8'd23;
   localparam logic [7:0] TOP_H12  = 8'd12;
   localparam logic [7:0] TOP_MIN  = 8'd59;
   localparam logic [7:0] TOP_DAY  = 8'd31;
   localparam logic [7:0] TOP_MON  = 8'd12;
   localparam logic [7:0] TOP_YEAR = 8'd99;
   localparam logic [7:0] TOP_WDAY = 8'd7;

   // Upper nibble times ten plus lower nibble; nibbles above nine pass through.
   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'd0, b[7:4]};
      return 8'((tens << 3) + (tens << 1) + {4'd0, b[3:0]});
   endfunction

   // Binary 0..99 to packed BCD; tens by multiply-by-reciprocal (103/1024).
   function automatic logic [7:0] bcd_encode(input logic [6:0] v);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 14'({7'd0, v} * 14'd103);
      tens = prod[13:10];
      ones = 7'(v - 7'(({3'd0, tens} << 3) + ({3'd0, tens} << 1)));
      return {tens, ones[3:0]};
   endfunction

   // Step up by one below the top, otherwise fall back to the low value.
   function automatic logic [7:0] step_wrap(input logic [7:0] v,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
      return (v < hi) ? 8'(v + 8'd1) : lo;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bcd_time_field_editor_unit.sv */
// Top level of the BCD time field editor: input register, edit core, result register.
// Depends on bte_pkg, bte_edit_core and assert_macros.svh.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_action / req_reg_value): one
//    transaction carries an action code and the current clock register byte.
//  - Response channel (rsp_valid / rsp_stall / rsp_new_value): one transaction
//    per request, in order, carrying the byte to write back.
//  - Path: a request taken at a clock edge passes through the input register, then
//    the result register, before it appears on the response channel.
//  - Throughput: one transaction per cycle while rsp_stall stays low; the edit
//    logic between the two pipeline registers is a single short pass.
//  - Stall: while rsp_stall holds a waiting result, the input register still
//    fills if empty; req_stall rises only once both registers are occupied.
//  - Reset (synchronous, active high) drops both valid flags; payloads are
//    left as they are.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcd_time_field_editor_unit
   import bte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_reg_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_new_value
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   action_type in_action_ff;
   logic [7:0] in_value_ff;

   // result register
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_value_ff;

   logic [7:0] edit_result;
   logic       out_load;
   logic       in_load;

   bte_edit_core u_core (
      .action    (in_action_ff),
      .reg_value (in_value_ff),
      .new_value (edit_result)
   );

   // Advance the result register when it is empty or its transaction leaves.
   assign out_load  = !out_valid_ff || !rsp_stall;
   // Hold a request only when the input register is full and cannot drain.
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payloads: capture on load, hold otherwise.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_action_ff <= action_type'(req_action);
         in_value_ff  <= req_reg_value;
      end
      if (out_load && in_valid_ff) begin
         out_value_ff <= edit_result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_new_value = out_value_ff;

   // A full pipeline blocked at the output must push back on the request side.
   `ASSERT_PROP(a_backpressure, clock, reset,
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
   // A transaction in the input register that moves on becomes a response.
   `ASSERT_PROP(a_advance, clock, reset,
      (in_valid_ff && out_load) |=> out_valid_ff)
   // The response carries the edit of the transaction that was loaded.
   `ASSERT_PROP(a_result, clock, reset,
      (in_valid_ff && out_load) |=> (rsp_new_value == $past(edit_result)))
   // Never drop a request: no acceptance while the input register cannot move.
   `ASSERT_NEVER(a_no_overrun, clock, reset,
      in_load && in_valid_ff && !out_load)

endmodule

`default_nettype wire

/* hw/rtl/bte_edit_core.sv */
// Combinational field editor: one register byte and action in, new byte out.
// Depends on bte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bte_edit_core
   import bte_pkg::*;
(
   input  action_type action,
   input  logic [7:0] reg_value,
   output logic [7:0] new_value
);

   logic       pm;
   logic       mode12;
   logic [7:0] h12_dec;
   logic [7:0] h24_dec;
   logic [7:0] h12_clip;
   logic [7:0] h24_clip;
   logic [7:0] to24_hour;
   logic [7:0] to12_hour;
   logic       to12_pm;
   logic [7:0] inc12_hour;
   logic       inc12_pm;
   logic [7:0] inc24_hour;
   logic [7:0] toggle_res;
   logic [7:0] hour_res;
   logic [7:0] min_step;
   logic [7:0] day_step;
   logic [7:0] mon_step;
   logic [7:0] year_step;

   assign pm      = reg_value[BIT_PM_POS];
   assign mode12  = reg_value[BIT_12H_POS];
   assign h12_dec = bcd_decode(reg_value & MASK_H12);
   assign h24_dec = bcd_decode(reg_value & MASK_H24);

   // 12 h to 24 h: an hour above twelve reads as one; twelve maps by PM
   always_comb begin
      h12_clip = (h12_dec > TOP_H12) ? 8'd1 : h12_dec;
      if (h12_clip == TOP_H12) begin
         to24_hour = pm ? TOP_H12 : 8'd0;
      end else begin
         to24_hour = pm ? 8'(h12_clip + TOP_H12) : h12_clip;
      end
   end

   // 24 h to 12 h: out-of-range hour reads as midnight
   always_comb begin
      h24_clip  = (h24_dec > TOP_H24) ? 8'd0 : h24_dec;
      to12_pm   = (h24_clip >= TOP_H12);
      to12_hour = to12_pm ? 8'(h24_clip - TOP_H12) : h24_clip;
      if (to12_hour == 8'd0) begin
         to12_hour = TOP_H12;
      end
   end

   always_comb begin
      inc24_hour = step_wrap(h24_dec, 8'd0, TOP_H24);
      inc12_hour = step_wrap(h12_dec, 8'd1, TOP_H12);
      inc12_pm   = pm ^ (inc12_hour == TOP_H12);
   end

   // Plain field steps; every result stays within 0..99
   always_comb begin
      min_step  = step_wrap(bcd_decode(reg_value & MASK_MIN), 8'd0, TOP_MIN);
      day_step  = step_wrap(bcd_decode(reg_value & MASK_DAY), 8'd1, TOP_DAY);
      mon_step  = step_wrap(bcd_decode(reg_value & MASK_MON), 8'd1, TOP_MON);
      year_step = step_wrap(bcd_decode(reg_value & MASK_YEAR), 8'd0, TOP_YEAR);
   end

   always_comb begin
      toggle_res = 8'd0;
      hour_res   = 8'd0;
      if (mode12) begin
         toggle_res = bcd_encode(to24_hour[6:0]);
         hour_res   = bcd_encode(inc12_hour[6:0]);
         hour_res[BIT_12H_POS] = 1'b1;
         hour_res[BIT_PM_POS]  = inc12_pm;
      end else begin
         toggle_res = bcd_encode(to12_hour[6:0]);
         toggle_res[BIT_12H_POS] = 1'b1;
         toggle_res[BIT_PM_POS]  = to12_pm;
         hour_res   = bcd_encode(inc24_hour[6:0]);
      end
   end

   always_comb begin
      new_value = reg_value;
      unique case (action)
         ACT_TOGGLE:  new_value = toggle_res;
         ACT_HOUR:    new_value = hour_res;
         ACT_MINUTE:  new_value = bcd_encode(min_step[6:0]);
         ACT_DAY:     new_value = bcd_encode(day_step[6:0]);
         ACT_MONTH:   new_value = bcd_encode(mon_step[6:0]);
         ACT_YEAR:    new_value = bcd_encode(year_step[6:0]);
         ACT_WEEKDAY: new_value = step_wrap(reg_value, 8'd1, TOP_WDAY);
         ACT_NONE:    new_value = reg_value;
      endcase
   end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bcd_time_field_editor_unit: directed edits, then random traffic.
// Depends on bte_pkg for action codes, register masks and field tops; needs only the RTL.

module testbench;
   import bte_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned RANDOM_EDITS  = 400;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned DRAIN_CYCLES  = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_action = ACT_NONE;
   logic [7:0] req_reg_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_new_value;

   // Bytes still owed by the block, oldest first.
   logic [7:0]  pending_bytes[$];
   logic [7:0]  owed_byte;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_enabled = 1'b1;

   bcd_time_field_editor_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_reg_value (req_reg_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_new_value (rsp_new_value)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor of the edited register byte
   // ---------------------------------------------------------------------

   // Packed BCD to binary; nibbles above nine simply enlarge the value.
   function automatic int unsigned from_bcd(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic logic [7:0] to_bcd(int unsigned n);
      return {4'((n / 10) % 10), 4'(n % 10)};
   endfunction

   // Step up inside the field, fall back to the low end from the top or above.
   function automatic int unsigned next_in_range(int unsigned v, int unsigned lo,
                                                 int unsigned hi);
      return (v < hi) ? v + 1 : lo;
   endfunction

   function automatic logic [7:0] edited_byte(action_type act, logic [7:0] r);
      int unsigned hour;
      logic        pm;
      logic [7:0]  result;
      pm = r[BIT_PM_POS];
      result = r;
      case (act)
         ACT_TOGGLE: begin
            if (r[BIT_12H_POS]) begin
               // 12 h to 24 h: hours above twelve count as one o'clock
               hour = from_bcd(r & MASK_H12);
               if (hour > 12) hour = 1;
               if (hour == 12) begin
                  if (!pm) hour = 0;
               end else if (pm) begin
                  hour += 12;
               end
               result = to_bcd(hour);
            end else begin
               // 24 h to 12 h: out-of-range hours count as midnight
               hour = from_bcd(r & MASK_H24);
               if (hour > int'(TOP_H24)) hour = 0;
               pm = (hour >= 12);
               if (pm) hour -= 12;
               if (hour == 0) hour = 12;
               result = to_bcd(hour);
               result[BIT_12H_POS] = 1'b1;
               result[BIT_PM_POS] = pm;
            end
         end
         ACT_HOUR: begin
            if (r[BIT_12H_POS]) begin
               hour = next_in_range(from_bcd(r & MASK_H12), 1, int'(TOP_H12));
               if (hour == 12) pm = ~pm;
               result = to_bcd(hour);
               result[BIT_12H_POS] = 1'b1;
               result[BIT_PM_POS] = pm;
            end else begin
               result = to_bcd(next_in_range(from_bcd(r & MASK_H24), 0, int'(TOP_H24)));
            end
         end
         ACT_MINUTE:
            result = to_bcd(next_in_range(from_bcd(r & MASK_MIN), 0, int'(TOP_MIN)));
         ACT_DAY:
            result = to_bcd(next_in_range(from_bcd(r & MASK_DAY), 1, int'(TOP_DAY)));
         ACT_MONTH:
            result = to_bcd(next_in_range(from_bcd(r & MASK_MON), 1, int'(TOP_MON)));
         ACT_YEAR:
            result = to_bcd(next_in_range(from_bcd(r & MASK_YEAR), 0, int'(TOP_YEAR)));
         // The weekday is a plain binary count over the whole byte.
         ACT_WEEKDAY: result = 8'(next_in_range(int'(r), 1, int'(TOP_WDAY)));
         default:    result = r;
      endcase
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Idling: mostly no gap or a short one, now and then a long one
   // ---------------------------------------------------------------------

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_enabled || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Stall the result channel in bursts; hold it low while idling is switched off.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Request side: one transaction per call, always entered at a rising edge
   // ---------------------------------------------------------------------

   task automatic send_edit(action_type act, logic [7:0] value);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_reg_value <= value;
      // Hold the payload until the block takes it.
      do @(posedge clock); while (req_stall);
      pending_bytes.push_back(edited_byte(act, value));
   endtask

   // ---------------------------------------------------------------------
   // Response side: compare every accepted byte with the oldest prediction
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result transaction: new_value=%02h", rsp_new_value);
         end else begin
            owed_byte = pending_bytes.pop_front();
            if (rsp_new_value !== owed_byte) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("new_value mismatch: expected %02h, actual %02h",
                           owed_byte, rsp_new_value);
            end
         end
      end
   end

   // Abandon a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Mode conversion both ways, including midnight, noon and out-of-range hours.
   task automatic test_toggle_mode();
      send_edit(ACT_TOGGLE, 8'h92);   // 12 am -> 00
      send_edit(ACT_TOGGLE, 8'hB2);   // 12 pm -> 12
      send_edit(ACT_TOGGLE, 8'hB1);   // 11 pm -> 23
      send_edit(ACT_TOGGLE, 8'h80);   // hour zero, am
      send_edit(ACT_TOGGLE, 8'hA0);   // hour zero, pm
      send_edit(ACT_TOGGLE, 8'h99);   // 12 h hour above twelve
      send_edit(ACT_TOGGLE, 8'h00);   // midnight -> 12 am
      send_edit(ACT_TOGGLE, 8'h23);   // 23 -> 11 pm
      send_edit(ACT_TOGGLE, 8'h3F);   // 24 h hour above 23
   endtask

   // Hour wrap in both modes and the PM flip on reaching twelve.
   task automatic test_hour_increment();
      send_edit(ACT_HOUR, 8'h23);
      send_edit(ACT_HOUR, 8'h3F);
      send_edit(ACT_HOUR, 8'h91);
      send_edit(ACT_HOUR, 8'hB1);
      send_edit(ACT_HOUR, 8'hB2);
   endtask

   // Top-of-range wrap, below-the-low-end step and raw over-range bytes.
   task automatic test_field_increments();
      send_edit(ACT_MINUTE, 8'h59);
      send_edit(ACT_DAY, 8'h00);
      send_edit(ACT_MONTH, 8'h12);
      send_edit(ACT_MONTH, 8'h1F);
      send_edit(ACT_YEAR, 8'h99);
      send_edit(ACT_YEAR, 8'hFF);
   endtask

   task automatic test_weekday_and_unused();
      send_edit(ACT_WEEKDAY, 8'h07);
      send_edit(ACT_WEEKDAY, 8'h00);
      send_edit(ACT_WEEKDAY, 8'hFF);
      send_edit(ACT_NONE, 8'hA5);
   endtask

   // Half well-formed register bytes for the chosen field, half raw bytes;
   // switch idling on and off in blocks so back-to-back stretches occur too.
   task automatic test_random_traffic();
      action_type  act;
      logic [7:0]  value;
      for (int unsigned n = 0; n < RANDOM_EDITS; n++) begin
         if (n % 50 == 0) idle_enabled = ($urandom_range(0, 2) != 0);
         act = action_type'($urandom_range(0, 7));
         value = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1)) begin
            case (act)
               ACT_TOGGLE, ACT_HOUR: begin
                  if ($urandom_range(0, 1)) begin
                     value = to_bcd($urandom_range(1, 12));
                     value[BIT_12H_POS] = 1'b1;
                     value[BIT_PM_POS] = 1'($urandom_range(0, 1));
                  end else begin
                     value = to_bcd($urandom_range(0, 23));
                  end
               end
               ACT_MINUTE:  value = to_bcd($urandom_range(0, 59));
               ACT_DAY:     value = to_bcd($urandom_range(1, 31));
               ACT_MONTH:   value = to_bcd($urandom_range(1, 12));
               ACT_YEAR:    value = to_bcd($urandom_range(0, 99));
               ACT_WEEKDAY: value = 8'($urandom_range(1, 7));
               default: ;
            endcase
         end
         send_edit(act, value);
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_toggle_mode();
      test_hour_increment();
      test_field_increments();
      test_weekday_and_unused();
      test_random_traffic();
      req_valid <= 1'b0;
      // Drain the pipeline, then give stray results a moment to show up.
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bte_pkg.sv
hw/rtl/bte_edit_core.sv
hw/rtl/bcd_time_field_editor_unit.sv
tb/sv/testbench.sv
